// File: hdl/isd_pkg.sv
package isd_pkg;

  // Default sizes
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int INPUT_BITS_DEF    = 32;
  localparam int MAX_CHECKS_DEF    = 16;

  // Beat field widths
  localparam int OP_W      = 2;
  localparam int STATE_W   = 32;
  localparam int IDX_W     = 4;
  localparam int KIND_W    = 2;
  localparam int MASK_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int BACKLOG_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RECORD      = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;

  // Check kinds
  localparam logic [KIND_W-1:0] KIND_PRESS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HELD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_HELD = 2'd3;

endpackage

// File: hdl/isd_if.sv
// Command channel
interface isd_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [isd_pkg::OP_W-1:0]      operation;
  logic [isd_pkg::STATE_W-1:0]   state_bits;
  logic [isd_pkg::IDX_W-1:0]     check_index;
  logic [isd_pkg::KIND_W-1:0]    check_kind;
  logic [isd_pkg::MASK_W-1:0]    check_mask;
  logic [isd_pkg::COUNT_W-1:0]   check_count;
  logic [isd_pkg::BACKLOG_W-1:0] backlog;

  modport source (
    output valid, operation, state_bits, check_index, check_kind, check_mask,
           check_count, backlog,
    input  ready
  );
  modport sink (
    input  valid, operation, state_bits, check_index, check_kind, check_mask,
           check_count, backlog,
    output ready
  );
endinterface

// Result channel
interface isd_rsp_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

// File: hdl/input_sequence_detector.sv
// Input sequence detector.
// cmd (sink): one beat carries an operation. Record appends a snapshot to
// the ring history, write-check loads one check table entry, query searches
// the newest history positions for the check sequence.
// rsp (source): one beat per query, carrying matched. Record and write-check
// beats, and the unused operation code, give no response.
// A query issues the first reads, primes the pipeline, walks back over up
// to N history positions at one history read per walk cycle, N being the
// clamped backlog (1 to 127), and loads the response register; a query with
// a check count of zero goes straight to the response register. The walk
// rate is set by the single read port of the history RAM.
// The response sits in an output register; record and write-check beats are
// still taken while it waits. A finished query holds until that register is
// free, and cmd stays not ready meanwhile.
// After reset the history RAM is zeroed, one entry a cycle; cmd is not ready
// during that pass. The check table is not cleared; entries must be written
// before a query uses them.
module input_sequence_detector #(
  parameter int HISTORY_DEPTH = isd_pkg::HISTORY_DEPTH_DEF,
  parameter int INPUT_BITS    = isd_pkg::INPUT_BITS_DEF,
  parameter int MAX_CHECKS    = isd_pkg::MAX_CHECKS_DEF
) (
  input logic        clk,
  input logic        rst,
  isd_cmd_if.sink    cmd,
  isd_rsp_if.source  rsp
);

  import isd_pkg::*;

  localparam int HAW      = $clog2(HISTORY_DEPTH);
  localparam int CAW      = (MAX_CHECKS > 1) ? $clog2(MAX_CHECKS) : 1;
  localparam int CNT_W    = $clog2(MAX_CHECKS + 1);
  localparam int CW       = KIND_W + INPUT_BITS;
  localparam int BL_MAX   = (1 << BACKLOG_W) - 1;
  localparam int STEP_CAP = (HISTORY_DEPTH - 1 < BL_MAX) ? HISTORY_DEPTH - 1 : BL_MAX;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PRIME,
    S_WALK,
    S_RESULT
  } state_t;

  state_t                  state;
  logic [HAW-1:0]          clr_ptr;
  logic [HAW-1:0]          wp;
  logic [HAW-1:0]          rd_ptr;
  logic [CAW-1:0]          chk;
  logic [BACKLOG_W-1:0]    steps;
  logic [INPUT_BITS-1:0]   cur_bits;
  logic [KIND_W-1:0]       chk_kind;
  logic [INPUT_BITS-1:0]   chk_mask;
  logic                    result;
  logic                    matched;
  logic                    rsp_valid;

  logic                    accept;
  logic                    is_record;
  logic                    is_write;
  logic                    is_query;
  logic                    idx_ok;
  logic [CNT_W-1:0]        count_sat;
  logic [BACKLOG_W-1:0]    steps_sat;
  logic                    met;
  logic [CAW-1:0]          chk_after;

  logic                    h_we;
  logic [HAW-1:0]          h_waddr;
  logic [INPUT_BITS-1:0]   h_wdata;
  logic [HAW-1:0]          h_raddr;
  logic [INPUT_BITS-1:0]   h_rdata;

  logic                    c_we;
  logic [CAW-1:0]          c_waddr;
  logic [CW-1:0]           c_wdata;
  logic [CAW-1:0]          c_raddr;
  logic [CW-1:0]           c_rdata;

  function automatic logic [HAW-1:0] ring_back(input logic [HAW-1:0] p);
    return (p == '0) ? HAW'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic check_met(input logic [KIND_W-1:0]     kind,
                                     input logic [INPUT_BITS-1:0] req,
                                     input logic [INPUT_BITS-1:0] cur,
                                     input logic [INPUT_BITS-1:0] old);
    logic [INPUT_BITS-1:0] diff;
    logic                  ok;
    diff = cur ^ old;
    unique case (kind)
      KIND_PRESS:    ok = ((req & diff & cur) == req);
      KIND_RELEASE:  ok = ((req & diff & old) == req);
      KIND_HELD:     ok = ((req & cur) == req);
      KIND_NOT_HELD: ok = ((req & cur) == '0);
      default:       ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Handshake and decode
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_record = accept && (cmd.operation == OP_RECORD);
  assign is_write  = accept && (cmd.operation == OP_WRITE_CHECK);
  assign is_query  = accept && (cmd.operation == OP_QUERY);
  assign idx_ok    = (32'(cmd.check_index) < MAX_CHECKS);

  assign rsp.valid   = rsp_valid;
  assign rsp.matched = matched;

  // Clamp count and backlog
  always_comb begin
    if (32'(cmd.check_count) > MAX_CHECKS) begin
      count_sat = CNT_W'(MAX_CHECKS);
    end else begin
      count_sat = CNT_W'(cmd.check_count);
    end
    if (cmd.backlog == '0) begin
      steps_sat = BACKLOG_W'(1);
    end else if (32'(cmd.backlog) > STEP_CAP) begin
      steps_sat = BACKLOG_W'(STEP_CAP);
    end else begin
      steps_sat = cmd.backlog;
    end
  end

  // Current check against the newly read older neighbour
  assign met       = check_met(chk_kind, chk_mask, cur_bits, h_rdata);
  assign chk_after = (state == S_WALK && met) ? chk - 1'b1 : chk;

  // History RAM port control
  assign h_we    = (state == S_CLEAR) || is_record;
  assign h_waddr = (state == S_CLEAR) ? clr_ptr : wp;
  assign h_wdata = (state == S_CLEAR) ? '0 : INPUT_BITS'(cmd.state_bits);

  always_comb begin
    unique case (state)
      S_IDLE:          h_raddr = ring_back(wp);
      S_PRIME, S_WALK: h_raddr = ring_back(rd_ptr);
      default:         h_raddr = rd_ptr;
    endcase
  end

  // Check RAM port control: read one entry ahead of the current check
  assign c_we    = is_write && idx_ok;
  assign c_waddr = CAW'(cmd.check_index);
  assign c_wdata = {cmd.check_kind, INPUT_BITS'(cmd.check_mask)};
  assign c_raddr = (state == S_IDLE) ? CAW'(count_sat - 1'b1) : chk_after - 1'b1;

  isd_ram #(
    .WIDTH (INPUT_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  isd_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_CHECKS)
  ) u_check_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // Sequencer, pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      wp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the result state reloads the register itself
      if (rsp_valid && rsp.ready && state != S_RESULT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == HAW'(HISTORY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (is_record) begin
            wp <= (wp == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
          end
          if (is_query) begin
            rd_ptr <= h_raddr;
            chk    <= CAW'(count_sat - 1'b1);
            steps  <= steps_sat;
            if (count_sat == '0) begin
              result <= 1'b0;
              state  <= S_RESULT;
            end else begin
              state  <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          rd_ptr   <= h_raddr;
          cur_bits <= h_rdata;
          chk_kind <= c_rdata[CW-1 -: KIND_W];
          chk_mask <= c_rdata[INPUT_BITS-1:0];
          state    <= S_WALK;
        end
        S_WALK: begin
          rd_ptr   <= h_raddr;
          cur_bits <= h_rdata;
          steps    <= steps - 1'b1;
          chk      <= chk_after;
          if (met) begin
            chk_kind <= c_rdata[CW-1 -: KIND_W];
            chk_mask <= c_rdata[INPUT_BITS-1:0];
          end
          if (met && chk == '0) begin
            result <= 1'b1;
            state  <= S_RESULT;
          end else if (steps == BACKLOG_W'(1)) begin
            result <= 1'b0;
            state  <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!rsp_valid || rsp.ready) begin
            matched   <= result;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new response beat only comes out of the result state
  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |-> $past(state == S_RESULT))
    else $error("response raised outside the result state");

  // The walk never runs with its step budget spent
  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps != '0))
    else $error("walk with zero steps left");

  // History is not written while a query reads it
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRIME || state == S_WALK) |-> !h_we)
    else $error("history write during a query");

  // Current check index stays inside the table
  a_chk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (32'(chk) < MAX_CHECKS))
    else $error("check index beyond the table");
`endif

endmodule

// File: hdl/isd_ram.sv
// Simple dual-port RAM, one write port, one registered read port
module isd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/input_sequence_detector_tb.sv
`timescale 1ns / 100ps

module input_sequence_detector_tb;
  import isd_pkg::*;

  localparam int DEPTH          = HISTORY_DEPTH_DEF;
  localparam int CHECKS         = MAX_CHECKS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_LEN       = 800;
  localparam int PHASE_BEATS    = 415;
  localparam int TAIL_CYCLES    = 200;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [STATE_W-1:0]   state_bits;
    logic [IDX_W-1:0]     check_index;
    logic [KIND_W-1:0]    check_kind;
    logic [MASK_W-1:0]    check_mask;
    logic [COUNT_W-1:0]   check_count;
    logic [BACKLOG_W-1:0] backlog;
  } cmd_beat_t;

  logic clk;
  logic rst;

  isd_cmd_if cmd_ch ();
  isd_rsp_if rsp_ch ();

  input_sequence_detector dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the detector state
  logic [STATE_W-1:0] hist_mem [DEPTH];
  int                 wr_slot;
  logic [KIND_W-1:0]  chk_kind [CHECKS];
  logic [MASK_W-1:0]  chk_mask [CHECKS];

  cmd_beat_t beat_queue [$];
  cmd_beat_t drive_beat;
  bit        want_match_q [$];

  int n_pushed;
  int gen_count;
  int n_accepted;
  int n_queries;
  int n_hits;
  int n_errors;
  int cmd_idle_pct;
  int rsp_idle_pct;
  bit hold_go;
  bit hold_done;
  int hold_cnt;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Walk back from the newest snapshot, meeting checks from the last used down to 0
  function automatic bit search_history(input logic [COUNT_W-1:0] count_in,
                                        input logic [BACKLOG_W-1:0] backlog_in);
    int                 used;
    int                 steps;
    int                 chk;
    int                 pos;
    int                 older;
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] prev;
    logic [MASK_W-1:0]  req;
    bit                 met;
    used = int'(count_in);
    if (used > CHECKS) used = CHECKS;
    if (used == 0) return 1'b0;
    steps = int'(backlog_in);
    if (steps == 0) steps = 1;
    if (steps > DEPTH - 1) steps = DEPTH - 1;
    chk = used - 1;
    pos = (wr_slot == 0) ? DEPTH - 1 : wr_slot - 1;
    while (steps != 0) begin
      older = (pos == 0) ? DEPTH - 1 : pos - 1;
      cur   = hist_mem[pos];
      prev  = hist_mem[older];
      req   = chk_mask[chk];
      case (chk_kind[chk])
        KIND_PRESS:   met = ((req & cur & ~prev) == req);
        KIND_RELEASE: met = ((req & ~cur & prev) == req);
        KIND_HELD:    met = ((req & cur) == req);
        default:      met = ((req & cur) == '0);
      endcase
      if (met) chk--;
      if (chk < 0) return 1'b1;
      pos = older;
      steps--;
    end
    return 1'b0;
  endfunction

  // Update the shadow state for one accepted beat
  task automatic apply_beat(input cmd_beat_t b);
    bit hit;
    case (b.op)
      OP_RECORD: begin
        hist_mem[wr_slot] = b.state_bits;
        wr_slot = (wr_slot + 1) % DEPTH;
      end
      OP_WRITE_CHECK: begin
        if (b.check_index < CHECKS) begin
          chk_kind[b.check_index] = b.check_kind;
          chk_mask[b.check_index] = b.check_mask;
        end
      end
      OP_QUERY: begin
        hit = search_history(b.check_count, b.backlog);
        want_match_q.push_back(hit);
        n_queries++;
        if (hit) n_hits++;
      end
      default: ;
    endcase
  endtask

  // Mostly sparse masks, with the odd empty or full one
  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(11, 0))
      0, 1, 2: return 32'h1 << $urandom_range(MASK_W - 1, 0);
      3, 4, 5: return $urandom() & $urandom() & $urandom();
      6, 7:    return $urandom() & $urandom();
      8:       return '1;
      9:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.op          = OP_W'($urandom_range(3, 0));
    b.state_bits  = $urandom();
    b.check_index = IDX_W'($urandom_range(15, 0));
    b.check_kind  = KIND_W'($urandom_range(3, 0));
    b.check_mask  = pick_mask();
    b.check_count = COUNT_W'($urandom_range(31, 0));
    b.backlog     = BACKLOG_W'(($urandom_range(9, 0) < 7) ? $urandom_range(15, 0) :
                                                            $urandom_range(127, 0));
    return b;
  endfunction

  task automatic push_beat(input cmd_beat_t b);
    beat_queue.push_back(b);
    n_pushed++;
    if (b.op != OP_UNUSED) gen_count++;
  endtask

  // Load a short check sequence, record snapshots that meet it in order, then query
  task automatic push_sequence();
    int                len;
    int                span;
    int                noise;
    cmd_beat_t         b;
    logic [KIND_W-1:0] kinds [4];
    logic [MASK_W-1:0] masks [4];
    len  = $urandom_range(4, 1);
    span = 0;
    for (int k = 0; k < len; k++) begin
      kinds[k]      = KIND_W'($urandom_range(3, 0));
      masks[k]      = pick_mask();
      b             = random_beat();
      b.op          = OP_WRITE_CHECK;
      b.check_index = IDX_W'(k);
      b.check_kind  = kinds[k];
      b.check_mask  = masks[k];
      push_beat(b);
    end
    for (int k = 0; k < len; k++) begin
      noise = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
      repeat (noise) begin
        b    = random_beat();
        b.op = OP_RECORD;
        push_beat(b);
        span++;
      end
      // edges need a prepared older neighbour
      if (kinds[k] == KIND_PRESS || kinds[k] == KIND_RELEASE) begin
        b            = random_beat();
        b.op         = OP_RECORD;
        b.state_bits = (kinds[k] == KIND_PRESS) ? (b.state_bits & ~masks[k]) :
                                                  (b.state_bits | masks[k]);
        push_beat(b);
        span++;
      end
      b            = random_beat();
      b.op         = OP_RECORD;
      b.state_bits = (kinds[k] == KIND_PRESS || kinds[k] == KIND_HELD) ?
                     (b.state_bits | masks[k]) : (b.state_bits & ~masks[k]);
      push_beat(b);
      span++;
    end
    b             = random_beat();
    b.op          = OP_QUERY;
    b.check_count = COUNT_W'(($urandom_range(4, 0) != 0) ? len : $urandom_range(31, 0));
    span = span + $urandom_range(2, 0) - (($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0);
    b.backlog     = BACKLOG_W'((span < 0) ? 0 : span);
    push_beat(b);
  endtask

  task automatic push_directed();
    cmd_beat_t b;
    // zero check count before any entry exists
    b = random_beat();
    b.op = OP_QUERY;
    b.check_count = 0;
    b.backlog = 0;
    push_beat(b);
    b = random_beat();
    b.op = OP_UNUSED;
    push_beat(b);
    // every entry, every kind, empty and full masks
    for (int i = 0; i < CHECKS; i++) begin
      b = random_beat();
      b.op = OP_WRITE_CHECK;
      b.check_index = IDX_W'(i);
      b.check_kind = KIND_W'(i % 4);
      b.check_mask = (i == 0) ? '0 : (i == CHECKS - 1) ? '1 : (32'h3 << (2 * i));
      push_beat(b);
    end
    b = random_beat();
    b.op = OP_RECORD;
    b.state_bits = '1;
    push_beat(b);
    b.state_bits = '0;
    push_beat(b);
    // backlog zero, saturated count with the longest walk across the ring end,
    // a sequence cut short by a one-position backlog, and the full table
    b = random_beat();
    b.op = OP_QUERY;
    b.check_count = 1;
    b.backlog = 0;
    push_beat(b);
    b.check_count = 31;
    b.backlog = 127;
    push_beat(b);
    b.check_count = 2;
    b.backlog = 1;
    push_beat(b);
    b.check_count = 16;
    b.backlog = 127;
    push_beat(b);
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || want_match_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int snd_idle, input int rcv_idle, input bit with_hold);
    int target;
    cmd_idle_pct = snd_idle;
    rsp_idle_pct = rcv_idle;
    if (with_hold) hold_go = 1'b1;
    target = gen_count + PHASE_BEATS;
    while (gen_count < target) begin
      if ($urandom_range(9, 0) < 7) push_sequence();
      else push_beat(random_beat());
    end
    drain();
  endtask

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_beat(drive_beat);
        n_accepted++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (beat_queue.size() != 0 && $urandom_range(99, 0) >= cmd_idle_pct) begin
          drive_beat = beat_queue.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.operation   <= drive_beat.op;
          cmd_ch.state_bits  <= drive_beat.state_bits;
          cmd_ch.check_index <= drive_beat.check_index;
          cmd_ch.check_kind  <= drive_beat.check_kind;
          cmd_ch.check_mask  <= drive_beat.check_mask;
          cmd_ch.check_count <= drive_beat.check_count;
          cmd_ch.backlog     <= drive_beat.backlog;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      rsp_ch.ready <= (hold_cnt == 0) && !(hold_go && !hold_done) &&
                      ($urandom_range(99, 0) >= rsp_idle_pct);
    end
  end

  // Response monitor and watchdog
  always @(posedge clk) begin : monitor
    bit want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (want_match_q.size() == 0) begin
          $error("unexpected response beat: matched=%0b", rsp_ch.matched);
          n_errors++;
        end else begin
          want = want_match_q.pop_front();
          if (rsp_ch.matched !== want) begin
            $error("matched: expected %0b, actual %0b", want, rsp_ch.matched);
            n_errors++;
          end
        end
      end
      if ((rsp_ch.valid && rsp_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.operation   = OP_RECORD;
    cmd_ch.state_bits  = '0;
    cmd_ch.check_index = '0;
    cmd_ch.check_kind  = KIND_PRESS;
    cmd_ch.check_mask  = '0;
    cmd_ch.check_count = '0;
    cmd_ch.backlog     = '0;
    rsp_ch.ready       = 1'b0;
    hold_go            = 1'b0;
    cmd_idle_pct       = 35;
    rsp_idle_pct       = 50;
    n_pushed           = 0;
    gen_count          = 0;
    n_accepted         = 0;
    n_queries          = 0;
    n_hits             = 0;
    n_errors           = 0;
    wr_slot            = 0;
    for (int i = 0; i < DEPTH; i++) hist_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_directed();
    run_phase(35, 50, 1'b0);
    run_phase(50, 35, 1'b0);
    // no idling, but one long response hold-off to back the block up
    run_phase(0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (want_match_q.size() != 0) begin
      $error("%0d responses never arrived", want_match_q.size());
      n_errors++;
    end
    $display("summary: %0d command beats, %0d queries (%0d expected to match)",
             n_accepted, n_queries, n_hits);
    $display("summary: three idling mixes and one response hold-off, %0d errors", n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
